FILE: rtl/gnpm_pkg.sv
package gnpm_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 18;

  localparam int INDEX_W   = 12;
  localparam int SCORE_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

  // 5.2e-5 * log2(e) and ln(2), both in Q32.
  localparam logic [31:0] SCORE_K  = 32'd322209;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SCORE,
    ST_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_Y_MUL,
    SC_Y_CHK,
    SC_U_MUL,
    SC_U_GET,
    SC_T_MUL,
    SC_T_GET,
    SC_D_MUL,
    SC_D_GET,
    SC_ACC,
    SC_FIN
  } score_state_t;

endpackage

FILE: rtl/gnpm_req_if.sv
interface gnpm_req_if import gnpm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, output req_type, output pos_x, output pos_y, output pos_z,
                  input ready);
  modport sink (input valid, input req_type, input pos_x, input pos_y, input pos_z,
                output ready);
endinterface

FILE: rtl/gnpm_res_if.sv
interface gnpm_res_if import gnpm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [INDEX_W-1:0]           match_index;
  logic signed [COORD_BITS-1:0] match_x;
  logic signed [COORD_BITS-1:0] match_y;
  logic signed [COORD_BITS-1:0] match_z;
  logic [DIST_W-1:0]            dist_squared;
  logic [SCORE_W-1:0]           match_score;

  modport source (output valid, output found, output match_index, output match_x,
                  output match_y, output match_z, output dist_squared, output match_score,
                  input ready);
  modport sink (input valid, input found, input match_index, input match_x,
                input match_y, input match_z, input dist_squared, input match_score,
                output ready);
endinterface

FILE: rtl/gnpm_score.sv
module gnpm_score import gnpm_pkg::*; #(
  parameter int DIST_W = 2 * COORD_BITS_DEF + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIST_W-1:0]  dist_in,
  output logic               done,
  output logic [SCORE_W-1:0] score
);

  localparam int DX_W = (DIST_W > 25) ? DIST_W : 25;

  score_state_t state_r, state_nxt;
  logic [32:0]        op_a_r, op_a_nxt;
  logic [31:0]        op_b_r, op_b_nxt;
  logic [64:0]        prod_r, prod_nxt;
  logic [4:0]         n_r, n_nxt;
  logic [31:0]        u_r, u_nxt;
  logic [33:0]        sum_r, sum_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [32:0]        quo_r, quo_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               done_r, done_nxt;

  logic [DX_W-1:0] dext;
  logic [33:0]     rnd;
  logic [33:0]     shifted;
  logic [32:0]     div_m;
  logic [5:0]      div_sh;
  logic [64:0]     prod_sh;

  // The one multiplier of the unit; every product goes through it.
  assign prod_nxt = 65'(op_a_r) * 65'(op_b_r);
  assign dext     = DX_W'(dist_in);
  assign rnd      = sum_r + (34'd1 << (5'd15 + n_r));
  assign shifted  = rnd >> (6'd16 + 6'(n_r));
  assign prod_sh  = prod_r >> div_sh;

  // Reciprocal of the term index, ceil(2^s / k), exact for every 32-bit term.
  always_comb begin
    case (k_r)
      4'd1: begin
        div_m  = 33'd4294967296;
        div_sh = 6'd32;
      end
      4'd2: begin
        div_m  = 33'd4294967296;
        div_sh = 6'd33;
      end
      4'd3: begin
        div_m  = 33'd5726623062;
        div_sh = 6'd34;
      end
      4'd4: begin
        div_m  = 33'd4294967296;
        div_sh = 6'd34;
      end
      4'd5: begin
        div_m  = 33'd6871947674;
        div_sh = 6'd35;
      end
      4'd6: begin
        div_m  = 33'd5726623062;
        div_sh = 6'd35;
      end
      4'd7: begin
        div_m  = 33'd4908534053;
        div_sh = 6'd35;
      end
      4'd8: begin
        div_m  = 33'd4294967296;
        div_sh = 6'd35;
      end
      4'd9: begin
        div_m  = 33'd7635497416;
        div_sh = 6'd36;
      end
      4'd10: begin
        div_m  = 33'd6871947674;
        div_sh = 6'd36;
      end
      4'd11: begin
        div_m  = 33'd6247225158;
        div_sh = 6'd36;
      end
      4'd12: begin
        div_m  = 33'd5726623062;
        div_sh = 6'd36;
      end
      default: begin
        div_m  = 33'd4294967296;
        div_sh = 6'd32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_a_r  <= op_a_nxt;
    op_b_r  <= op_b_nxt;
    prod_r  <= prod_nxt;
    n_r     <= n_nxt;
    u_r     <= u_nxt;
    sum_r   <= sum_nxt;
    k_r     <= k_nxt;
    quo_r   <= quo_nxt;
    score_r <= score_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_a_nxt  = op_a_r;
    op_b_nxt  = op_b_r;
    n_nxt     = n_r;
    u_nxt     = u_r;
    sum_nxt   = sum_r;
    k_nxt     = k_r;
    quo_nxt   = quo_r;
    score_nxt = score_r;
    done_nxt  = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          if (|dext[DX_W-1:24]) begin
            score_nxt = '0;
            done_nxt  = 1'b1;
          end else begin
            op_a_nxt  = 33'(dext[23:0]);
            op_b_nxt  = SCORE_K;
            state_nxt = SC_Y_MUL;
          end
        end
      end
      SC_Y_MUL: state_nxt = SC_Y_CHK;
      SC_Y_CHK: begin
        // Integer part of the base-2 exponent; beyond 16 the score rounds to zero.
        if (prod_r[64:32] >= 33'd17) begin
          score_nxt = '0;
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end else begin
          n_nxt     = prod_r[36:32];
          op_a_nxt  = {1'b0, prod_r[31:0]};
          op_b_nxt  = LN2_Q32;
          state_nxt = SC_U_MUL;
        end
      end
      SC_U_MUL: state_nxt = SC_U_GET;
      SC_U_GET: begin
        u_nxt     = prod_r[63:32];
        op_a_nxt  = 33'h1_0000_0000;
        op_b_nxt  = prod_r[63:32];
        sum_nxt   = 34'h1_0000_0000;
        k_nxt     = 4'd1;
        state_nxt = SC_T_MUL;
      end
      SC_T_MUL: state_nxt = SC_T_GET;
      SC_T_GET: begin
        // The new term is below 2^32, so the division by k is one more product.
        op_a_nxt  = div_m;
        op_b_nxt  = prod_r[63:32];
        state_nxt = SC_D_MUL;
      end
      SC_D_MUL: state_nxt = SC_D_GET;
      SC_D_GET: begin
        quo_nxt   = prod_sh[32:0];
        state_nxt = SC_ACC;
      end
      SC_ACC: begin
        if (k_r[0]) begin
          sum_nxt = sum_r - {1'b0, quo_r};
        end else begin
          sum_nxt = sum_r + {1'b0, quo_r};
        end
        if (k_r == TAYLOR_TERMS) begin
          state_nxt = SC_FIN;
        end else begin
          k_nxt     = k_r + 4'd1;
          op_a_nxt  = quo_r;
          op_b_nxt  = u_r;
          state_nxt = SC_T_MUL;
        end
      end
      SC_FIN: begin
        if (|shifted[33:16]) begin
          score_nxt = '1;
        end else begin
          score_nxt = shifted[15:0];
        end
        done_nxt  = 1'b1;
        state_nxt = SC_IDLE;
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  assign done  = done_r;
  assign score = score_r;

endmodule

FILE: rtl/gaussian_nearest_point_matcher_top.sv
// Channel  | Direction | Payload                                                 | Transfer
// in_req   | sink      | req_type, pos_x, pos_y, pos_z                           | valid & ready
// out_res  | source    | found, match_index, match_x/y/z, dist_squared, score    | valid & ready
// cfg_*    | sink      | cfg_index, cfg_data (box bounds)                        | cfg_we
//
// Clear and load requests are handled while idle; a load writes one store entry
// if there is room and the point is inside the box. A query scans the stored
// points one per cycle through the read, difference, square and sum stages into
// the best-match register, then the score unit runs (ending early when the score
// is zero by range): one multiplier for the exponent split and twelve series terms,
// each divided by its index through a reciprocal product. A query on an empty store
// goes straight to the output. Reset is synchronous; the store is not cleared.
// The input stays not ready until the query result is held in the output
// register, which waits there for as long as the sink stalls.
module gaussian_nearest_point_matcher_top import gnpm_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gnpm_req_if.sink              in_req,
  gnpm_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int PT_W   = 3 * COORD_BITS;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  // Box bounds.
  logic signed [COORD_BITS-1:0] box_min_x_r, box_max_x_r;
  logic signed [COORD_BITS-1:0] box_min_y_r, box_max_y_r;
  logic signed [COORD_BITS-1:0] box_min_z_r, box_max_z_r;

  top_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic in_ready, in_fire, in_box;
  logic mem_we, query_start, score_start, out_load;
  logic score_done;
  logic [SCORE_W-1:0] score_val;

  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;

  // Point store and the distance pipeline.
  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [PT_W-1:0] rd_pt_r, pt2_r, pt3_r, pt4_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIST_W-1:0] px, py, pz;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0] d4_r;

  logic              best_any_r;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [PT_W-1:0]   best_pt_r;
  logic              best_upd;

  // Output register.
  logic                         out_found_r;
  logic [INDEX_W-1:0]           out_idx_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r, out_z_r;
  logic [DIST_W-1:0]            out_d_r;
  logic [SCORE_W-1:0]           out_score_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_req.valid && in_ready;
  assign in_box   = (in_req.pos_x >= box_min_x_r) && (in_req.pos_x <= box_max_x_r) &&
                    (in_req.pos_y >= box_min_y_r) && (in_req.pos_y <= box_max_y_r) &&
                    (in_req.pos_z >= box_min_z_r) && (in_req.pos_z <= box_max_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= COORD_MIN;
      box_max_x_r <= COORD_MAX;
      box_min_y_r <= COORD_MIN;
      box_max_y_r <= COORD_MAX;
      box_min_z_r <= COORD_MIN;
      box_max_z_r <= COORD_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_MIN_X: box_min_x_r <= cfg_data;
        CFG_BOX_MAX_X: box_max_x_r <= cfg_data;
        CFG_BOX_MIN_Y: box_min_y_r <= cfg_data;
        CFG_BOX_MAX_Y: box_max_y_r <= cfg_data;
        CFG_BOX_MIN_Z: box_min_z_r <= cfg_data;
        CFG_BOX_MAX_Z: box_max_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    mem_we        = 1'b0;
    query_start   = 1'b0;
    score_start   = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req.req_type)
            REQ_CLEAR: count_nxt = '0;
            REQ_LOAD: begin
              if ((count_r < CNT_W'(MAX_POINTS)) && in_box) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_QUERY: begin
              query_start   = 1'b1;
              scan_addr_nxt = '0;
              if (count_r == '0) begin
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_addr_nxt = scan_addr_r + IDX_W'(1);
        if (CNT_W'(scan_addr_r) == count_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v1_r || v2_r || v3_r || v4_r)) begin
          score_start = 1'b1;
          state_nxt   = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (score_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= {in_req.pos_x, in_req.pos_y, in_req.pos_z};
    end
    rd_pt_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      qx_r <= in_req.pos_x;
      qy_r <= in_req.pos_y;
      qz_r <= in_req.pos_z;
    end
  end

  assign rd_x = rd_pt_r[PT_W-1 -: COORD_BITS];
  assign rd_y = rd_pt_r[2*COORD_BITS-1 -: COORD_BITS];
  assign rd_z = rd_pt_r[COORD_BITS-1:0];
  assign px   = dx_r * dx_r;
  assign py   = dy_r * dy_r;
  assign pz   = dz_r * dz_r;
  // Later points win ties, hence the less-or-equal.
  assign best_upd = v4_r && (!best_any_r || (d4_r <= best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      best_any_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_SCAN);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (query_start) begin
        best_any_r <= 1'b0;
      end else if (best_upd) begin
        best_any_r <= 1'b1;
      end
    end
    idx1_r <= scan_addr_r;
    dx_r   <= DIFF_W'(rd_x) - DIFF_W'(qx_r);
    dy_r   <= DIFF_W'(rd_y) - DIFF_W'(qy_r);
    dz_r   <= DIFF_W'(rd_z) - DIFF_W'(qz_r);
    pt2_r  <= rd_pt_r;
    idx2_r <= idx1_r;
    sqx_r  <= px[SQ_W-1:0];
    sqy_r  <= py[SQ_W-1:0];
    sqz_r  <= pz[SQ_W-1:0];
    pt3_r  <= pt2_r;
    idx3_r <= idx2_r;
    d4_r   <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
    pt4_r  <= pt3_r;
    idx4_r <= idx3_r;
    if (best_upd) begin
      best_d_r   <= d4_r;
      best_idx_r <= idx4_r;
      best_pt_r  <= pt4_r;
    end
  end

  gnpm_score #(
    .DIST_W(DIST_W)
  ) u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (score_start),
    .dist_in (best_d_r),
    .done    (score_done),
    .score   (score_val)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= best_any_r;
      if (best_any_r) begin
        out_idx_r   <= INDEX_W'(best_idx_r);
        out_x_r     <= best_pt_r[PT_W-1 -: COORD_BITS];
        out_y_r     <= best_pt_r[2*COORD_BITS-1 -: COORD_BITS];
        out_z_r     <= best_pt_r[COORD_BITS-1:0];
        out_d_r     <= best_d_r;
        out_score_r <= score_val;
      end else begin
        out_idx_r   <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
        out_d_r     <= '0;
        out_score_r <= '0;
      end
    end
  end

  assign in_req.ready         = in_ready;
  assign out_res.valid        = out_valid_r;
  assign out_res.found        = out_found_r;
  assign out_res.match_index  = out_idx_r;
  assign out_res.match_x      = out_x_r;
  assign out_res.match_y      = out_y_r;
  assign out_res.match_z      = out_z_r;
  assign out_res.dist_squared = out_d_r;
  assign out_res.match_score  = out_score_r;

endmodule

FILE: rtl/gnpm_checker.sv
module gnpm_checker import gnpm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found,
  input logic [INDEX_W-1:0]        out_match_index,
  input logic [2*COORD_BITS+1:0]   out_dist_squared,
  input logic [SCORE_W-1:0]        out_match_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_match_index) && $stable(out_dist_squared) && $stable(out_match_score))
    else $error("result changed while stalled");

  // A query keeps the input side closed at least until its scan starts.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_QUERY) |=> !in_ready)
    else $error("input ready right after a query transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      (out_match_index == '0) && (out_dist_squared == '0) && (out_match_score == '0))
    else $error("empty-store result carries nonzero fields");

  // An exact hit scores one, which saturates.
  a_exact_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && (out_dist_squared == '0) |-> (out_match_score == '1))
    else $error("exact hit without full score");

endmodule

bind gaussian_nearest_point_matcher_top gnpm_checker #(
  .COORD_BITS(COORD_BITS)
) u_gnpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .in_req_type      (in_req.req_type),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_found        (out_res.found),
  .out_match_index  (out_res.match_index),
  .out_dist_squared (out_res.dist_squared),
  .out_match_score  (out_res.match_score)
);

FILE: tb/gaussian_nearest_point_matcher_top_tb.sv
`timescale 1ns / 1ps

module gaussian_nearest_point_matcher_top_tb;
  import gnpm_pkg::*;

  localparam int DIST_W        = 2 * COORD_BITS_DEF + 2;
  localparam int COORD_MIN     = -(1 << (COORD_BITS_DEF - 1));
  localparam int COORD_MAX     = (1 << (COORD_BITS_DEF - 1)) - 1;
  localparam int SETTLE_CYCLES = 20;
  // The one request code that the block leaves unused.
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] idx;
    coord_t             mx;
    coord_t             my;
    coord_t             mz;
    logic [DIST_W-1:0]  dist_sq;
    logic [SCORE_W-1:0] score;
  } match_t;

  typedef struct {
    logic [1:0] kind;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    bit         typed;
    match_t     want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [COORD_BITS_DEF-1:0] cfg_data;

  gnpm_req_if #(.COORD_BITS(COORD_BITS_DEF)) req_ch ();
  gnpm_res_if #(.COORD_BITS(COORD_BITS_DEF)) res_ch ();

  gaussian_nearest_point_matcher_top #(
    .MAX_POINTS(MAX_POINTS_DEF),
    .COORD_BITS(COORD_BITS_DEF)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the point store, the point count and the box bounds.
  coord_t      stored_x [MAX_POINTS_DEF];
  coord_t      stored_y [MAX_POINTS_DEF];
  coord_t      stored_z [MAX_POINTS_DEF];
  int unsigned stored_count;
  coord_t      box_lo [3];
  coord_t      box_hi [3];

  match_t      pending_matches [$];
  stim_row_t   stim_table [$];
  int          err_count = 0;
  int          send_calm = 0;
  int          take_calm = 0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Mostly random idle gaps, with occasional runs of back-to-back transfers.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 30);
    return $urandom_range(0, 16);
  endfunction

  function automatic coord_t rand_coord(input int spread);
    if (spread <= 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic longint unsigned sq_diff(input coord_t a, input coord_t b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return diff * diff;
  endfunction

  // exp(-5.2e-5 * d^2) in Q0.16: split into 2^-n * exp(-u), the fraction by a
  // truncated Taylor series in Q32, then rounded and saturated.
  function automatic logic [SCORE_W-1:0] gauss_score(input longint unsigned dsq);
    longint unsigned y, n, f, u, acc, term, r;
    int k;
    if (dsq >= (64'd1 << 24)) return '0;
    y = dsq * SCORE_K;
    n = y >> 32;
    if (n >= 17) return '0;
    f = y & 64'hFFFF_FFFF;
    u = (f * LN2_Q32) >> 32;
    acc = 64'd1 << 32;
    term = acc;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * u) >> 32) / k;
      if (k % 2 == 1) acc -= term;
      else acc += term;
    end
    r = (acc + (64'd1 << (15 + n))) >> (16 + n);
    if (r > 65535) r = 65535;
    return r[SCORE_W-1:0];
  endfunction

  // Updates the mirrored state for one accepted request; returns 1 when the
  // request produces a result, which is then left in m.
  function automatic bit apply_request(input logic [1:0] kind, input coord_t px, py, pz,
                                       output match_t m);
    longint unsigned d, best_d;
    int unsigned i, best;
    m = '0;
    best_d = 0;
    best = 0;
    if (kind == REQ_CLEAR) begin
      stored_count = 0;
      return 1'b0;
    end
    if (kind == REQ_LOAD) begin
      if (stored_count < MAX_POINTS_DEF &&
          px >= box_lo[0] && px <= box_hi[0] &&
          py >= box_lo[1] && py <= box_hi[1] &&
          pz >= box_lo[2] && pz <= box_hi[2]) begin
        stored_x[stored_count] = px;
        stored_y[stored_count] = py;
        stored_z[stored_count] = pz;
        stored_count++;
      end
      return 1'b0;
    end
    if (kind != REQ_QUERY) return 1'b0;
    if (stored_count == 0) return 1'b1;
    for (i = 0; i < stored_count; i++) begin
      d = sq_diff(stored_x[i], px) + sq_diff(stored_y[i], py) + sq_diff(stored_z[i], pz);
      // Equal distances go to the later point.
      if (i == 0 || d <= best_d) begin
        best_d = d;
        best = i;
      end
    end
    m.found   = 1'b1;
    m.idx     = best[INDEX_W-1:0];
    m.mx      = stored_x[best];
    m.my      = stored_y[best];
    m.mz      = stored_z[best];
    m.dist_sq = best_d[DIST_W-1:0];
    m.score   = gauss_score(best_d);
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input int x, y, z,
                                  input bit typed = 1'b0, input bit found = 1'b0,
                                  input int idx = 0, input int mx = 0, input int my = 0,
                                  input int mz = 0, input longint dist_sq = 0,
                                  input int score = 0);
    stim_row_t row;
    row.kind         = kind;
    row.x            = coord_t'(x);
    row.y            = coord_t'(y);
    row.z            = coord_t'(z);
    row.typed        = typed;
    row.want.found   = found;
    row.want.idx     = idx[INDEX_W-1:0];
    row.want.mx      = coord_t'(mx);
    row.want.my      = coord_t'(my);
    row.want.mz      = coord_t'(mz);
    row.want.dist_sq = dist_sq[DIST_W-1:0];
    row.want.score   = score[SCORE_W-1:0];
    stim_table = {stim_table, row};
  endfunction

  task automatic send_req(input logic [1:0] kind, input coord_t x, y, z,
                          input bit typed = 1'b0, input match_t want = '0);
    int gap;
    match_t pred;
    gap = draw_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= 2'($urandom);
      req_ch.pos_x    <= coord_t'($urandom);
      req_ch.pos_y    <= coord_t'($urandom);
      req_ch.pos_z    <= coord_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.pos_x    <= x;
    req_ch.pos_y    <= y;
    req_ch.pos_z    <= z;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (apply_request(kind, x, y, z, pred)) pending_matches = {pending_matches,
                                                               (typed ? want : pred)};
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_box(input int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z);
    logic [CFG_IDX_W-1:0] reg_idx [6];
    int reg_val [6];
    int k;
    reg_idx = '{CFG_BOX_MIN_X, CFG_BOX_MAX_X, CFG_BOX_MIN_Y,
                CFG_BOX_MAX_Y, CFG_BOX_MIN_Z, CFG_BOX_MAX_Z};
    reg_val = '{lo_x, hi_x, lo_y, hi_y, lo_z, hi_z};
    for (k = 0; k < 6; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx[k];
      cfg_data  <= reg_val[k][COORD_BITS_DEF-1:0];
      case (reg_idx[k])
        CFG_BOX_MIN_X: box_lo[0] = coord_t'(reg_val[k]);
        CFG_BOX_MAX_X: box_hi[0] = coord_t'(reg_val[k]);
        CFG_BOX_MIN_Y: box_lo[1] = coord_t'(reg_val[k]);
        CFG_BOX_MAX_Y: box_hi[1] = coord_t'(reg_val[k]);
        CFG_BOX_MIN_Z: box_lo[2] = coord_t'(reg_val[k]);
        CFG_BOX_MAX_Z: box_hi[2] = coord_t'(reg_val[k]);
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads cluster around the origin so queries land near stored points; a few
  // full-range values, clears and unused request codes are mixed in.
  task automatic random_traffic(input int items, input int spread);
    int pick, j, s;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      s = ($urandom_range(0, 9) == 0) ? 0 : spread;
      if (pick < 3) begin
        send_req(REQ_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0));
      end else if (pick < 6) begin
        send_req(REQ_RESERVED, rand_coord(0), rand_coord(0), rand_coord(0));
      end else if (pick < 55) begin
        send_req(REQ_LOAD, rand_coord(s), rand_coord(s), rand_coord(s));
      end else if (stored_count != 0 && $urandom_range(0, 2) != 0) begin
        j = $urandom_range(0, stored_count - 1);
        send_req(REQ_QUERY, stored_x[j] + rand_coord(4), stored_y[j] + rand_coord(4),
                 stored_z[j] + rand_coord(4));
      end else begin
        send_req(REQ_QUERY, rand_coord(s), rand_coord(s), rand_coord(s));
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    match_t got, want;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(take_calm);
      @(negedge clk);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.found   = res_ch.found;
      got.idx     = res_ch.match_index;
      got.mx      = res_ch.match_x;
      got.my      = res_ch.match_y;
      got.mz      = res_ch.match_z;
      got.dist_sq = res_ch.dist_squared;
      got.score   = res_ch.match_score;
      if (pending_matches.size() == 0) begin
        report_mismatch("result transfers with none pending", 1, 0);
      end else begin
        want = pending_matches.pop_front();
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.idx !== want.idx) report_mismatch("match_index", got.idx, want.idx);
        if (got.mx !== want.mx) report_mismatch("match_x", got.mx, want.mx);
        if (got.my !== want.my) report_mismatch("match_y", got.my, want.my);
        if (got.mz !== want.mz) report_mismatch("match_z", got.mz, want.mz);
        if (got.dist_sq !== want.dist_sq) begin
          report_mismatch("dist_squared", got.dist_sq, want.dist_sq);
        end
        if (got.score !== want.score) report_mismatch("match_score", got.score, want.score);
      end
    end
  end

  initial begin : main_flow
    int lo [3];
    int hi [3];
    int a;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_CLEAR;
    req_ch.pos_x    = '0;
    req_ch.pos_y    = '0;
    req_ch.pos_z    = '0;
    stored_count    = 0;

    add_row(REQ_QUERY, 0, 0, 0, 1'b1);
    add_row(REQ_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
    add_row(REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 0,
            COORD_MAX, COORD_MAX, COORD_MAX, 0, 65535);
    add_row(REQ_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
    add_row(REQ_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1,
            COORD_MIN, COORD_MIN, COORD_MIN, 0, 65535);
    add_row(REQ_QUERY, COORD_MIN, COORD_MAX, COORD_MIN);
    add_row(REQ_QUERY, 0, 0, 0);
    add_row(REQ_CLEAR, 0, 0, 0);
    add_row(REQ_QUERY, 5, 5, 5, 1'b1);
    add_row(REQ_RESERVED, 7, 7, 7);
    add_row(REQ_QUERY, 7, 7, 7, 1'b1);
    add_row(REQ_LOAD, 10, 0, 0);
    add_row(REQ_LOAD, -10, 0, 0);
    add_row(REQ_QUERY, 0, 0, 0);
    add_row(REQ_LOAD, 0, 0, -9);
    add_row(REQ_QUERY, 0, 0, 0);
    // Around the last nonzero power-of-two step and the 2^24 distance cutoff.
    add_row(REQ_QUERY, 485, 0, 0);
    add_row(REQ_QUERY, 487, 0, 0);
    add_row(REQ_QUERY, 4106, 0, 0);
    add_row(REQ_QUERY, 100, -3, 2);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    foreach (stim_table[r])
      send_req(stim_table[r].kind, stim_table[r].x, stim_table[r].y, stim_table[r].z,
               stim_table[r].typed, stim_table[r].want);
    random_traffic(35, 3000);
    drain_results();

    for (a = 0; a < 3; a++) begin
      lo[a] = -int'($urandom_range(500, 3000));
      hi[a] = $urandom_range(500, 3000);
    end
    set_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
    random_traffic(25, 4000);
    drain_results();

    // Inverted x window: every load is turned away.
    set_box(1000, -1000, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    random_traffic(10, 2000);
    drain_results();

    set_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_req(REQ_CLEAR, 0, 0, 0);
    send_req(REQ_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
    send_req(REQ_LOAD, COORD_MAX - 1, COORD_MAX, COORD_MAX);
    send_req(REQ_QUERY, 0, 0, 0);
    drain_results();

    set_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_req(REQ_CLEAR, 0, 0, 0);
    send_req(REQ_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
    send_req(REQ_LOAD, COORD_MIN, COORD_MIN, COORD_MIN + 1);
    send_req(REQ_QUERY, 0, 0, 0);
    drain_results();

    // A tight cluster, random queries around it, then a query on the last point loaded.
    set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    send_req(REQ_CLEAR, 0, 0, 0);
    repeat (8) send_req(REQ_LOAD, rand_coord(20), rand_coord(20), rand_coord(20));
    repeat (5) send_req(REQ_QUERY, rand_coord(30), rand_coord(30), rand_coord(30));
    send_req(REQ_QUERY, stored_x[stored_count-1], stored_y[stored_count-1],
             stored_z[stored_count-1]);
    send_req(REQ_CLEAR, 0, 0, 0);
    random_traffic(25, 3000);
    drain_results();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
